// ===== design/hevm_pkg.sv =====
// ----------------------------------------------------------------------------
// hevm_pkg: shared types and constants for the haptic voice mixer
// Payload structs, item codes, controller states, command/status bundles.
// ----------------------------------------------------------------------------
package hevm_pkg;

  localparam int MAX_VOICES_DEF  = 20;
  localparam int MAX_STEPS_DEF   = 256;
  localparam int NUM_EFFECTS_DEF = 16;

  localparam int FUNC_W  = 3;
  localparam int EID_W   = 4;
  localparam int GAIN_W  = 12;
  localparam int SIDX_W  = 8;
  localparam int AMP_W   = 8;
  localparam int LEN_W   = 9;
  localparam int STR_W   = 12;
  localparam int DRIVE_W = 8;
  // drive = (sum * strength) >> FRAC_W
  localparam int FRAC_W  = 16;

  localparam logic [STR_W-1:0] STRENGTH_RESET = 12'd256;

  // item codes
  localparam logic [FUNC_W-1:0] FUNC_UPDATE     = 3'd0;
  localparam logic [FUNC_W-1:0] FUNC_TRIGGER    = 3'd1;
  localparam logic [FUNC_W-1:0] FUNC_STOP       = 3'd2;
  localparam logic [FUNC_W-1:0] FUNC_SET_LENGTH = 3'd3;
  localparam logic [FUNC_W-1:0] FUNC_WRITE_STEP = 3'd4;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic              hand;
    logic              advance;
    logic [EID_W-1:0]  effect_id;
    logic [GAIN_W-1:0] gain;
    logic [SIDX_W-1:0] step_index;
    logic [AMP_W-1:0]  step_amplitude;
    logic [LEN_W-1:0]  length;
  } in_t;

  typedef struct packed {
    logic               out_hand;
    logic [DRIVE_W-1:0] drive;
    logic               last;
  } out_t;

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_VREAD = 6'b000010,
    ST_VCHK  = 6'b000100,
    ST_VACC  = 6'b001000,
    ST_SCALE = 6'b010000,
    ST_EMIT  = 6'b100000
  } state_e;

  // controller -> datapath
  typedef struct packed {
    logic accept;     // input transaction taken this cycle
    logic vrd;        // read voice k, k++
    logic chk;        // keep voice: write back at w, w++, read envelope byte
    logic acc;        // sum += envelope * gain
    logic scale;      // scaled = sum * strength
    logic emit;       // load output register, store compacted count
    logic next_hand;  // move on to hand 1
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic op_update;
    logic op_stop;
    logic k_done;
    logic live;
    logic out_free;
    logic last_hand;
  } sts_t;

endpackage

// ===== design/haptic_envelope_voice_mixer_core.sv =====
// ----------------------------------------------------------------------------
// haptic_envelope_voice_mixer_core: two-hand haptic envelope voice mixer
// Stores effect envelopes, plays up to MAX_VOICES voices per hand and mixes
// them into one saturated drive byte per hand.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o / in_data_i): one transaction is one
//   item. Trigger, set-length and write-step items finish on the accept edge
//   and produce nothing. A stop item clears the hand and returns one result
//   (drive 0, last set). An update item returns hand 0 then hand 1 (last set).
//   Output channel (out_valid_o / out_stall_i / out_data_o): a result sits in
//   an output register until taken; the next item can be accepted meanwhile.
//   Sequencing: a stop result is loaded in the EMIT state that follows accept,
//   once the output register is free. An update walks the voice list of each
//   hand through the voice memory: per hand VREAD, then VCHK for every voice
//   plus VACC for each live one, then SCALE and EMIT, where EMIT waits while
//   the receiver holds stall on an earlier result. Hand 1 then follows hand 0.
//   The block takes one item at a time; in_stall_o is high while an update or
//   stop is in flight, including while an emit waits for a stalled receiver
//   to free the output register.
//   cfg_we_i/cfg_wdata_i write effect_strength (Q4.8); write only when idle.
//   Reset: voice counts, effect lengths and defined flags clear, strength
//   returns to 1.0. Envelope and voice memories are not cleared.
// ----------------------------------------------------------------------------
module haptic_envelope_voice_mixer_core #(
  parameter int MAX_VOICES  = hevm_pkg::MAX_VOICES_DEF,
  parameter int MAX_STEPS   = hevm_pkg::MAX_STEPS_DEF,
  parameter int NUM_EFFECTS = hevm_pkg::NUM_EFFECTS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // item channel
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  hevm_pkg::in_t               in_data_i,
  // result channel
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output hevm_pkg::out_t              out_data_o,
  // strength register
  input  logic                        cfg_we_i,
  input  logic [hevm_pkg::STR_W-1:0]  cfg_wdata_i
);

  // controller <-> datapath
  hevm_pkg::cmd_t cmd;
  hevm_pkg::sts_t sts;

  // Sequencer: accepts items in idle, steps the voice walk, orders emits.
  hevm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Datapath: effect table, memories, multiply-accumulate, output register.
  hevm_dp #(
    .MAX_VOICES  (MAX_VOICES),
    .MAX_STEPS   (MAX_STEPS),
    .NUM_EFFECTS (NUM_EFFECTS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .in_data_i   (in_data_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o)
  );

endmodule

// ===== design/hevm_ctrl.sv =====
// ----------------------------------------------------------------------------
// hevm_ctrl: sequencing state machine of the haptic voice mixer
// Walks the voice list of each hand and orders scale and emit.
// ----------------------------------------------------------------------------
module hevm_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  hevm_pkg::sts_t  sts_i,
  output hevm_pkg::cmd_t  cmd_o
);

  hevm_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= hevm_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o = (state_q != hevm_pkg::ST_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      hevm_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          if (sts_i.op_update) begin
            state_d = hevm_pkg::ST_VREAD;
          end else if (sts_i.op_stop) begin
            state_d = hevm_pkg::ST_EMIT;
          end
        end
      end
      hevm_pkg::ST_VREAD: begin
        if (sts_i.k_done) begin
          state_d = hevm_pkg::ST_SCALE;
        end else begin
          cmd_o.vrd = 1'b1;
          state_d   = hevm_pkg::ST_VCHK;
        end
      end
      hevm_pkg::ST_VCHK: begin
        if (sts_i.live) begin
          cmd_o.chk = 1'b1;
          state_d   = hevm_pkg::ST_VACC;
        end else if (sts_i.k_done) begin
          state_d = hevm_pkg::ST_SCALE;
        end else begin
          cmd_o.vrd = 1'b1;
        end
      end
      hevm_pkg::ST_VACC: begin
        cmd_o.acc = 1'b1;
        if (sts_i.k_done) begin
          state_d = hevm_pkg::ST_SCALE;
        end else begin
          cmd_o.vrd = 1'b1;
          state_d   = hevm_pkg::ST_VCHK;
        end
      end
      hevm_pkg::ST_SCALE: begin
        cmd_o.scale = 1'b1;
        state_d     = hevm_pkg::ST_EMIT;
      end
      hevm_pkg::ST_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          if (sts_i.last_hand) begin
            state_d = hevm_pkg::ST_IDLE;
          end else begin
            cmd_o.next_hand = 1'b1;
            state_d         = hevm_pkg::ST_VREAD;
          end
        end
      end
      default: begin
        state_d = hevm_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// ===== design/hevm_dp.sv =====
// ----------------------------------------------------------------------------
// hevm_dp: datapath of the haptic voice mixer
// Effect table, envelope and voice memories, mix accumulator, output register.
// ----------------------------------------------------------------------------
module hevm_dp #(
  parameter int MAX_VOICES  = hevm_pkg::MAX_VOICES_DEF,
  parameter int MAX_STEPS   = hevm_pkg::MAX_STEPS_DEF,
  parameter int NUM_EFFECTS = hevm_pkg::NUM_EFFECTS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  hevm_pkg::cmd_t                cmd_i,
  output hevm_pkg::sts_t                sts_o,
  input  hevm_pkg::in_t                 in_data_i,
  input  logic                          cfg_we_i,
  input  logic [hevm_pkg::STR_W-1:0]    cfg_wdata_i,
  input  logic                          out_stall_i,
  output logic                          out_valid_o,
  output hevm_pkg::out_t                out_data_o
);

  localparam int EID_W  = hevm_pkg::EID_W;
  localparam int GAIN_W = hevm_pkg::GAIN_W;
  localparam int EIW    = (NUM_EFFECTS > 1) ? $clog2(NUM_EFFECTS) : 1;
  localparam int SW     = $clog2(MAX_STEPS + 1);
  localparam int CW     = $clog2(MAX_VOICES + 1);
  localparam int VDEPTH = 2 * MAX_VOICES;
  localparam int VAW    = $clog2(VDEPTH);
  localparam int EDEPTH = NUM_EFFECTS * MAX_STEPS;
  localparam int EAW    = $clog2(EDEPTH);
  localparam int VW     = EID_W + SW + GAIN_W;
  localparam int PW     = hevm_pkg::AMP_W + GAIN_W;
  localparam int SUMW   = PW + CW;
  localparam int SCW    = SUMW + hevm_pkg::STR_W;
  localparam int FRAC_W = hevm_pkg::FRAC_W;
  localparam int DRV_W  = hevm_pkg::DRIVE_W;

  // ---- registers ----
  logic [hevm_pkg::STR_W-1:0] strength_q;
  logic [CW-1:0]              count_q [2];
  logic [SW-1:0]              eff_len_q [NUM_EFFECTS];
  logic [NUM_EFFECTS-1:0]     eff_def_q;
  logic [VW-1:0]              voice_mem [VDEPTH];
  logic [VW-1:0]              voice_rd_q;
  logic [hevm_pkg::AMP_W-1:0] env_mem [EDEPTH];
  logic [hevm_pkg::AMP_W-1:0] env_rd_q;
  logic [CW-1:0]              k_q, w_q;
  logic                       hand_q, adv_q, op_stop_q;
  logic [SUMW-1:0]            sum_q;
  logic [SCW-1:0]             scaled_q;
  hevm_pkg::out_t             out_q;
  logic                       out_valid_q;

  // ---- input decode ----
  logic                 is_update, is_trigger, is_stop, is_setlen, is_wrstep;
  logic [EIW+EID_W-1:0] in_eid_ext;
  logic [EIW-1:0]       in_eidx;
  logic                 in_eid_ok, sidx_ok, trig_ok;
  logic [CW-1:0]        count_cur;
  logic [SW-1:0]        in_len_sat;
  logic [VAW-1:0]       trig_addr;
  logic [EAW-1:0]       env_waddr;

  assign is_update  = (in_data_i.func == hevm_pkg::FUNC_UPDATE);
  assign is_trigger = (in_data_i.func == hevm_pkg::FUNC_TRIGGER);
  assign is_stop    = (in_data_i.func == hevm_pkg::FUNC_STOP);
  assign is_setlen  = (in_data_i.func == hevm_pkg::FUNC_SET_LENGTH);
  assign is_wrstep  = (in_data_i.func == hevm_pkg::FUNC_WRITE_STEP);

  assign in_eid_ext = {{EIW{1'b0}}, in_data_i.effect_id};
  assign in_eidx    = in_eid_ext[EIW-1:0];
  assign in_eid_ok  = (in_eid_ext < (EIW + EID_W)'(NUM_EFFECTS));
  assign sidx_ok    = (32'(in_data_i.step_index) < 32'(MAX_STEPS));
  assign count_cur  = count_q[in_data_i.hand];
  assign trig_ok    = (count_cur < CW'(MAX_VOICES)) && in_eid_ok && eff_def_q[in_eidx];
  assign in_len_sat = (32'(in_data_i.length) > 32'(MAX_STEPS)) ? SW'(MAX_STEPS)
                                                                 : SW'(in_data_i.length);
  assign trig_addr  = VAW'(in_data_i.hand) * VAW'(MAX_VOICES) + VAW'(count_cur);
  assign env_waddr  = EAW'(in_eidx) * EAW'(MAX_STEPS) + EAW'(in_data_i.step_index);

  // ---- voice under test ----
  logic [EID_W-1:0]     rd_eff;
  logic [SW-1:0]        rd_step, wb_step;
  logic [GAIN_W-1:0]    rd_gain;
  logic [EIW+EID_W-1:0] rd_eid_ext;
  logic [EIW-1:0]       rd_eidx;
  logic [SW-1:0]        rd_len;
  logic                 live;
  logic [VAW-1:0]       loop_base, vrd_addr, wb_addr;
  logic [EAW-1:0]       env_raddr;

  assign rd_eff     = voice_rd_q[VW-1 -: EID_W];
  assign rd_step    = voice_rd_q[GAIN_W +: SW];
  assign rd_gain    = voice_rd_q[GAIN_W-1:0];
  assign rd_eid_ext = {{EIW{1'b0}}, rd_eff};
  assign rd_eidx    = rd_eid_ext[EIW-1:0];
  assign rd_len     = (rd_eid_ext < (EIW + EID_W)'(NUM_EFFECTS)) ? eff_len_q[rd_eidx] : '0;
  assign live       = (rd_step < rd_len);
  assign wb_step    = adv_q ? rd_step + SW'(1) : rd_step;
  assign loop_base  = VAW'(hand_q) * VAW'(MAX_VOICES);
  assign vrd_addr   = loop_base + VAW'(k_q);
  assign wb_addr    = loop_base + VAW'(w_q);
  assign env_raddr  = EAW'(rd_eidx) * EAW'(MAX_STEPS) + EAW'(rd_step);

  // ---- voice memory: one write port, one registered read port ----
  logic           v_we;
  logic [VAW-1:0] v_waddr;
  logic [VW-1:0]  v_wdata;

  always_comb begin
    v_we    = 1'b0;
    v_waddr = wb_addr;
    v_wdata = {rd_eff, wb_step, rd_gain};
    if (cmd_i.accept && is_trigger && trig_ok) begin
      v_we    = 1'b1;
      v_waddr = trig_addr;
      v_wdata = {in_data_i.effect_id, {SW{1'b0}}, in_data_i.gain};
    end else if (cmd_i.chk) begin
      v_we = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (v_we) begin
      voice_mem[v_waddr] <= v_wdata;
    end
    if (cmd_i.vrd) begin
      voice_rd_q <= voice_mem[vrd_addr];
    end
  end

  // ---- envelope memory ----
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept && is_wrstep && in_eid_ok && sidx_ok) begin
      env_mem[env_waddr] <= in_data_i.step_amplitude;
    end
    if (cmd_i.chk) begin
      env_rd_q <= env_mem[env_raddr];
    end
  end

  // ---- effect table, counts, strength ----
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      strength_q <= hevm_pkg::STRENGTH_RESET;
      count_q[0] <= '0;
      count_q[1] <= '0;
      eff_def_q  <= '0;
      for (int i = 0; i < NUM_EFFECTS; i++) begin
        eff_len_q[i] <= '0;
      end
    end else begin
      if (cfg_we_i) begin
        strength_q <= cfg_wdata_i;
      end
      if (cmd_i.accept) begin
        if (is_trigger && trig_ok) begin
          count_q[in_data_i.hand] <= count_cur + CW'(1);
        end
        if (is_stop) begin
          count_q[in_data_i.hand] <= '0;
        end
        if (is_setlen && in_eid_ok) begin
          eff_len_q[in_eidx] <= in_len_sat;
          eff_def_q[in_eidx] <= 1'b1;
        end
      end else if (cmd_i.emit && !op_stop_q) begin
        count_q[hand_q] <= w_q;  // compacted list
      end
    end
  end

  // ---- mix loop control ----
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q       <= '0;
      w_q       <= '0;
      hand_q    <= 1'b0;
      adv_q     <= 1'b0;
      op_stop_q <= 1'b0;
    end else begin
      if (cmd_i.accept && (is_update || is_stop)) begin
        k_q       <= '0;
        w_q       <= '0;
        hand_q    <= is_stop ? in_data_i.hand : 1'b0;
        adv_q     <= in_data_i.advance;
        op_stop_q <= is_stop;
      end else if (cmd_i.next_hand) begin
        k_q    <= '0;
        w_q    <= '0;
        hand_q <= 1'b1;
      end else begin
        if (cmd_i.vrd) begin
          k_q <= k_q + CW'(1);
        end
        if (cmd_i.chk) begin
          w_q <= w_q + CW'(1);
        end
      end
    end
  end

  // ---- accumulate and scale ----
  logic [PW-1:0] prod;
  assign prod = env_rd_q * rd_gain;

  always_ff @(posedge clk_i) begin
    if ((cmd_i.accept && is_update) || cmd_i.next_hand) begin
      sum_q <= '0;
    end else if (cmd_i.acc) begin
      sum_q <= sum_q + SUMW'(prod);
    end
    if (cmd_i.scale) begin
      scaled_q <= SCW'(sum_q) * SCW'(strength_q);
    end
  end

  logic [DRV_W-1:0] drive_sat;
  assign drive_sat = (|scaled_q[SCW-1:FRAC_W+DRV_W]) ? {DRV_W{1'b1}}
                                                     : scaled_q[FRAC_W +: DRV_W];

  // ---- output register ----
  logic out_free;
  assign out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_q.out_hand <= hand_q;
      out_q.drive    <= op_stop_q ? '0 : drive_sat;
      out_q.last     <= op_stop_q || hand_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign sts_o.op_update = is_update;
  assign sts_o.op_stop   = is_stop;
  assign sts_o.k_done    = (k_q >= count_q[hand_q]);
  assign sts_o.live      = live;
  assign sts_o.out_free  = out_free;
  assign sts_o.last_hand = op_stop_q || hand_q;

  // ---- assertions ----
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q[0] <= CW'(MAX_VOICES)) && (count_q[1] <= CW'(MAX_VOICES)))
    else $error("voice count above limit");

  a_compact_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    w_q <= k_q)
    else $error("write pointer passed read pointer");

  a_acc_after_chk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.acc |-> $past(cmd_i.chk))
    else $error("accumulate without envelope read");

  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit |-> out_free)
    else $error("emit into occupied output register");

  a_emit_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit |=> out_valid_q)
    else $error("emitted result not presented");

endmodule
